>>> rtl/core/dfs_pkg.sv
package dfs_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned VidW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = VidW + 1;

  typedef logic [VidW-1:0]        vid_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [MaxVertices-1:0] vset_t;

  // item kinds
  localparam logic KindLoad  = 1'b0;
  localparam logic KindStart = 1'b1;

  localparam cnt_t VertexCountRst = cnt_t'(MaxVertices);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ROOT   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_EMIT   = 5'b01000,
    S_ERR    = 5'b10000
  } seq_state_e;

  // result request from the sequencer to the output register
  typedef struct packed {
    logic valid;
    cnt_t vertex_number;
    logic last;
    logic range_error;
  } dfs_emit_t;

endpackage

>>> rtl/core/dfs_if.sv
interface dfs_in_if;
  logic          valid;
  logic          ready;
  logic          kind;
  dfs_pkg::vid_t  row_index;
  dfs_pkg::vset_t row_bits;
  dfs_pkg::cnt_t  start_vertex;

  modport source (output valid, kind, row_index, row_bits, start_vertex, input ready);
  modport sink   (input valid, kind, row_index, row_bits, start_vertex, output ready);
endinterface

interface dfs_out_if;
  logic          valid;
  logic          ready;
  dfs_pkg::cnt_t vertex_number;
  logic          last;
  logic          range_error;

  modport source (output valid, vertex_number, last, range_error, input ready);
  modport sink   (input valid, vertex_number, last, range_error, output ready);
endinterface

>>> rtl/core/dfs_ffs.sv
module dfs_ffs (
  input  dfs_pkg::vset_t operand_i,
  output logic           found_o,
  output dfs_pkg::vid_t  index_o,
  output dfs_pkg::vset_t onehot_o
);
  import dfs_pkg::*;

  vset_t lowest;

  // isolate the lowest set bit, then encode it
  assign lowest   = operand_i & (~operand_i + vset_t'(1));
  assign found_o  = |operand_i;
  assign onehot_o = lowest;

  always_comb begin
    index_o = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      index_o = index_o | ({VidW{lowest[i]}} & VidW'(i));
    end
  end

endmodule

>>> rtl/core/dfs_adj_store.sv
module dfs_adj_store (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  dfs_pkg::vid_t  waddr_i,
  input  dfs_pkg::vset_t wdata_i,
  input  dfs_pkg::vid_t  raddr_i,
  output dfs_pkg::vset_t rdata_o
);
  import dfs_pkg::*;

  vset_t rows_q [MaxVertices];
  vset_t row_valid_q;

  // a row never loaded reads as no edges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (we_i) begin
      row_valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rows_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = row_valid_q[raddr_i] ? rows_q[raddr_i] : '0;

endmodule

>>> rtl/core/dfs_seq.sv
module dfs_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  dfs_in_if.sink             in_i,
  input  dfs_pkg::cnt_t      vertex_count_i,
  input  logic               slot_free_i,
  output dfs_pkg::dfs_emit_t emit_o
);
  import dfs_pkg::*;

  seq_state_e state_q, state_d;
  cnt_t       n_q, n_d;
  vid_t       start_q, start_d;
  logic       wrap_q, wrap_d;
  vset_t      visited_q, visited_d;
  cnt_t       depth_q, depth_d;
  vid_t       cur_q, cur_d;
  cnt_t       fc_q, fc_d;
  vid_t       emit_q, emit_d;

  vid_t stack_q [MaxVertices];
  vid_t fin_q   [MaxVertices];

  logic  acc;
  cnt_t  n_in;
  vset_t used_mask;
  vset_t geq_mask;
  vset_t unvisited;
  vset_t adj_row;
  vset_t ffs_op;
  logic  ffs_found;
  vid_t  ffs_idx;
  vset_t ffs_hot;
  cnt_t  depth_m2;
  logic  stack_we;
  vid_t  stack_waddr;
  logic  fin_we;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign n_in       = (vertex_count_i > VertexCountRst) ? VertexCountRst : vertex_count_i;

  assign used_mask = (n_q >= VertexCountRst) ? '1
                   : ((vset_t'(1) << n_q[VidW-1:0]) - vset_t'(1));
  assign geq_mask  = '1 << start_q;
  assign unvisited = ~visited_q & used_mask;
  assign depth_m2  = depth_q - cnt_t'(2);

  dfs_adj_store u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (acc && (in_i.kind == KindLoad)),
    .waddr_i (in_i.row_index),
    .wdata_i (in_i.row_bits),
    .raddr_i (cur_q),
    .rdata_o (adj_row)
  );

  // shared find-first unit: next root or next successor
  always_comb begin
    if (state_q == S_ROOT) begin
      ffs_op = wrap_q ? unvisited : (unvisited & geq_mask);
    end else begin
      ffs_op = adj_row & unvisited;
    end
  end

  dfs_ffs u_ffs (
    .operand_i (ffs_op),
    .found_o   (ffs_found),
    .index_o   (ffs_idx),
    .onehot_o  (ffs_hot)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    start_d     = start_q;
    wrap_d      = wrap_q;
    visited_d   = visited_q;
    depth_d     = depth_q;
    cur_d       = cur_q;
    fc_d        = fc_q;
    emit_d      = emit_q;
    stack_we    = 1'b0;
    stack_waddr = depth_q[VidW-1:0];
    fin_we      = 1'b0;
    emit_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (acc && (in_i.kind == KindStart)) begin
          if (in_i.start_vertex >= n_in) begin
            state_d = S_ERR;
          end else begin
            n_d       = n_in;
            start_d   = in_i.start_vertex[VidW-1:0];
            wrap_d    = 1'b0;
            visited_d = '0;
            fc_d      = '0;
            state_d   = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (ffs_found) begin
          visited_d   = visited_q | ffs_hot;
          stack_we    = 1'b1;
          stack_waddr = '0;
          depth_d     = cnt_t'(1);
          cur_d       = ffs_idx;
          state_d     = S_SEARCH;
        end else if (wrap_q) begin
          emit_d  = VidW'(fc_q - cnt_t'(1));
          state_d = S_EMIT;
        end else begin
          wrap_d = 1'b1;
        end
      end
      S_SEARCH: begin
        if (ffs_found) begin
          visited_d = visited_q | ffs_hot;
          stack_we  = 1'b1;
          depth_d   = depth_q + cnt_t'(1);
          cur_d     = ffs_idx;
        end else begin
          fin_we  = 1'b1;
          fc_d    = fc_q + cnt_t'(1);
          depth_d = depth_q - cnt_t'(1);
          if (depth_q == cnt_t'(1)) begin
            state_d = S_ROOT;
          end else begin
            cur_d = stack_q[depth_m2[VidW-1:0]];
          end
        end
      end
      S_EMIT: begin
        if (slot_free_i) begin
          emit_o.valid         = 1'b1;
          emit_o.vertex_number = cnt_t'(fin_q[emit_q]) + cnt_t'(1);
          emit_o.last          = (emit_q == '0);
          if (emit_q == '0) begin
            state_d = S_IDLE;
          end else begin
            emit_d = emit_q - vid_t'(1);
          end
        end
      end
      S_ERR: begin
        if (slot_free_i) begin
          emit_o.valid       = 1'b1;
          emit_o.last        = 1'b1;
          emit_o.range_error = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= '0;
      start_q   <= '0;
      wrap_q    <= 1'b0;
      visited_q <= '0;
      depth_q   <= '0;
      cur_q     <= '0;
      fc_q      <= '0;
      emit_q    <= '0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      start_q   <= start_d;
      wrap_q    <= wrap_d;
      visited_q <= visited_d;
      depth_q   <= depth_d;
      cur_q     <= cur_d;
      fc_q      <= fc_d;
      emit_q    <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_q[stack_waddr] <= cur_d;
    end
    if (fin_we) begin
      fin_q[fc_q[VidW-1:0]] <= cur_q;
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= VertexCountRst)
    else $error("search stack deeper than vertex limit");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (fc_q != '0) && (fc_q <= n_q))
    else $error("emit phase with bad finish count");

  a_visited_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ROOT) || (state_q == S_SEARCH)) |-> ((visited_q & ~used_mask) == '0))
    else $error("vertex outside used range marked visited");

  a_search_has_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (depth_q != '0))
    else $error("search step with empty stack");

endmodule

>>> rtl/core/dfs_topological_order.sv
// channel   dir  payload                                       transfer when
// in_i      in   kind, row_index, row_bits, start_vertex      valid && ready
// out_o     out  vertex_number, last, range_error             valid && ready
// cfg       in   cfg_wdata_i (vertex_count)                   cfg_we_i high
//
// a load item writes one adjacency row; ready is low while a sort runs
// a sort of n vertices: each vertex is pushed once and popped once (a root push is
//   its own probe), plus one wrap probe and one final probe, then the finished
//   vertices are emitted in reverse finish order
// an out-of-range start gives one error result once out_o is free
// output back-pressure stalls only the emit and error phases; reset clears the
//   row valid bits at once, so no clearing pass is needed
module dfs_topological_order (
  input  logic          clk_i,
  input  logic          rst_ni,
  dfs_in_if.sink        in_i,
  dfs_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  dfs_pkg::cnt_t cfg_wdata_i
);
  import dfs_pkg::*;

  cnt_t      vertex_count_q;
  dfs_emit_t emit;
  logic      slot_free;

  logic out_valid_q;
  cnt_t out_vertex_q;
  logic out_last_q;
  logic out_err_q;

  // vertex count register, sampled by the sequencer when a sort starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VertexCountRst;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  // output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_q || out_o.ready;

  dfs_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .vertex_count_i (vertex_count_q),
    .slot_free_i    (slot_free),
    .emit_o         (emit)
  );

  // output register between the sequencer and the result channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_vertex_q <= emit.vertex_number;
      out_last_q   <= emit.last;
      out_err_q    <= emit.range_error;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.vertex_number = out_vertex_q;
  assign out_o.last          = out_last_q;
  assign out_o.range_error   = out_err_q;

  a_emit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> slot_free)
    else $error("result pushed into a full output register");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid && emit.range_error |-> emit.last && (emit.vertex_number == '0))
    else $error("malformed error result");

  a_no_input_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> !in_i.ready)
    else $error("input accepted during result phase");

endmodule
